// ===== sv/ucpe_pkg.sv =====
// Shared types, widths and codes for the URL common-prefix encoder.
package ucpe_pkg;

	// Fixed field widths
	localparam int LEN_W = 7;   // string length / byte position
	localparam int CNT_W = 3;   // closed-string count and string index
	localparam int TOT_W = 10;  // encoding size in bytes
	localparam int CAP_W = 10;  // output capacity register

	localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_OVF     = 2'd2;

	// Byte source for the packer
	localparam logic [1:0] SRC_PLEN = 2'd0;  // prefix length byte
	localparam logic [1:0] SRC_MEM  = 2'd1;  // byte read from the string store
	localparam logic [1:0] SRC_SLEN = 2'd2;  // suffix length byte

	typedef struct packed {
		logic [7:0] url_byte;
		logic       last_url;
	} in_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic [1:0]  status;
		logic        last_word;
	} out_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic       in_take;
		logic       set_clr;
		logic       scan_init;
		logic       rd_en;
		logic       rd_p;
		logic       ref_ld;
		logic       p_inc;
		logic       i_clr;
		logic       i_inc;
		logic       j_zero;
		logic       j_ld_p;
		logic       j_inc;
		logic       tot_ld;
		logic       app;
		logic [1:0] app_src;
		logic       app_last;
		logic       err;
		logic [1:0] err_status;
	} ctl_t;

	// Datapath -> controller status
	typedef struct packed {
		logic in_final;
		logic ovf;
		logic cnt_zero;
		logic p_ge_min;
		logic i_first;
		logic i_last;
		logic mismatch;
		logic p_zero;
		logic j_last_pfx;
		logic len_gt_p;
		logic j_last_sfx;
		logic cap_over;
		logic slot_free;
	} sts_t;

endpackage

// ===== sv/ucpe_dp.sv =====
// Datapath: string store, set state, prefix scan counters, byte packer and output register.
module ucpe_dp #(
	parameter int MAX_URLS    = 2,
	parameter int URL_MAX_LEN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ucpe_pkg::ctl_t               ctl,
	output ucpe_pkg::sts_t               sts,
	input  ucpe_pkg::in_t                in_data,
	input  logic                         cfg_wr_en,
	input  logic [ucpe_pkg::CAP_W-1:0]   cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ucpe_pkg::out_t               out_data
);

	localparam int DEPTH = MAX_URLS * URL_MAX_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LIW   = (MAX_URLS > 1) ? $clog2(MAX_URLS) : 1;
	localparam int LW    = ucpe_pkg::LEN_W;
	localparam int CW    = ucpe_pkg::CNT_W;
	localparam int TW    = ucpe_pkg::TOT_W;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    ref_q;

	logic [LW-1:0] len_q [MAX_URLS];
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] pos_q;
	logic          ovf_q;
	logic [ucpe_pkg::CAP_W-1:0] cap_q;

	logic [LW-1:0] p_q;
	logic [LW-1:0] j_q;
	logic [CW-1:0] i_q;
	logic [TW-1:0] tot_q;

	logic [63:0]   word_q;
	logic [2:0]    pcnt_q;
	ucpe_pkg::out_t out_q;
	logic          out_valid_q;

	logic          cnt_full;
	logic          pos_full;
	logic          byte_nz;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [LW-1:0] rd_pos;
	logic [LW-1:0] len_i;
	logic [LW-1:0] min_len;
	logic [TW-1:0] tot_sum;
	logic [7:0]    app_byte;
	logic [63:0]   word_nxt;
	logic          flush;
	logic          slot_free;

	assign byte_nz  = (in_data.url_byte != 8'd0);
	assign cnt_full = (cnt_q >= CW'(MAX_URLS));
	assign pos_full = (pos_q >= LW'(URL_MAX_LEN));
	assign waddr    = AW'(32'(cnt_q) * URL_MAX_LEN + 32'(pos_q));
	assign rd_pos   = ctl.rd_p ? p_q : j_q;
	assign raddr    = AW'(32'(i_q) * URL_MAX_LEN + 32'(rd_pos));
	assign len_i    = len_q[i_q[LIW-1:0]];

	// String store: one write port for loading, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.in_take && byte_nz && !cnt_full && !pos_full) begin
			mem[waddr] <= in_data.url_byte;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (ctl.ref_ld) begin
			ref_q <= rdata_q;
		end
	end

	// Set state: lengths, count, write position, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_URLS; k++) begin
				len_q[k] <= '0;
			end
			cnt_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.set_clr) begin
			for (int k = 0; k < MAX_URLS; k++) begin
				len_q[k] <= '0;
			end
			cnt_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.in_take) begin
			if (byte_nz) begin
				if (cnt_full || pos_full) begin
					ovf_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else begin
				if (cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q[cnt_q[LIW-1:0]] <= pos_q;
					cnt_q <= cnt_q + 1'b1;
				end
				pos_q <= '0;
			end
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ucpe_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Scan and emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (ctl.scan_init) begin
				p_q <= '0;
			end else if (ctl.p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (ctl.scan_init || ctl.i_clr) begin
				i_q <= '0;
			end else if (ctl.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (ctl.j_zero) begin
				j_q <= '0;
			end else if (ctl.j_ld_p) begin
				j_q <= p_q;
			end else if (ctl.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// Shortest closed string bounds the prefix
	always_comb begin
		min_len = len_q[0];
		for (int k = 1; k < MAX_URLS; k++) begin
			if (k < int'(cnt_q) && len_q[k] < min_len) begin
				min_len = len_q[k];
			end
		end
	end

	// Encoding size: length byte, prefix, then length byte and suffix per string
	always_comb begin
		tot_sum = TW'(1) + TW'(p_q);
		for (int k = 0; k < MAX_URLS; k++) begin
			if (k < int'(cnt_q)) begin
				tot_sum = tot_sum + TW'(1) + TW'(len_q[k]) - TW'(p_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tot_ld) begin
			tot_q <= tot_sum;
		end
	end

	// Byte packer
	always_comb begin
		unique case (ctl.app_src)
			ucpe_pkg::SRC_PLEN: app_byte = 8'(p_q);
			ucpe_pkg::SRC_MEM:  app_byte = rdata_q;
			ucpe_pkg::SRC_SLEN: app_byte = 8'(len_i - p_q);
			default:            app_byte = 8'd0;
		endcase
		word_nxt = word_q;
		word_nxt[{pcnt_q, 3'b000} +: 8] = app_byte;
	end

	assign flush     = ctl.app && ((pcnt_q == 3'd7) || ctl.app_last);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
		end else if (ctl.scan_init || flush) begin
			pcnt_q <= '0;
		end else if (ctl.app) begin
			pcnt_q <= pcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_init || flush) begin
			word_q <= '0;
		end else if (ctl.app) begin
			word_q <= word_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.err || flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.err) begin
			out_q.out_bytes  <= '0;
			out_q.byte_count <= '0;
			out_q.status     <= ctl.err_status;
			out_q.last_word  <= 1'b1;
		end else if (flush) begin
			out_q.out_bytes  <= word_nxt;
			out_q.byte_count <= 4'(pcnt_q) + 4'd1;
			out_q.status     <= ucpe_pkg::ST_OK;
			out_q.last_word  <= ctl.app_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller
	assign sts.in_final   = !byte_nz && in_data.last_url;
	assign sts.ovf        = ovf_q;
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.p_ge_min   = (p_q >= min_len);
	assign sts.i_first    = (i_q == '0);
	assign sts.i_last     = (i_q == CW'(cnt_q - 1'b1));
	assign sts.mismatch   = (rdata_q != ref_q);
	assign sts.p_zero     = (p_q == '0);
	assign sts.j_last_pfx = (({1'b0, j_q} + 1'b1) == {1'b0, p_q});
	assign sts.len_gt_p   = (len_i > p_q);
	assign sts.j_last_sfx = (({1'b0, j_q} + 1'b1) == {1'b0, len_i});
	assign sts.cap_over   = (tot_q > TW'(cap_q));
	assign sts.slot_free  = slot_free;

endmodule

// ===== sv/ucpe_ctrl.sv =====
// Controller: sequences loading, prefix scan, size check and emission.
module ucpe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ucpe_pkg::sts_t sts,
	output ucpe_pkg::ctl_t ctl
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SRD   = 4'd2;
	localparam logic [3:0] S_SCMP  = 4'd3;
	localparam logic [3:0] S_TOT   = 4'd4;
	localparam logic [3:0] S_CAP   = 4'd5;
	localparam logic [3:0] S_EOVF  = 4'd6;
	localparam logic [3:0] S_ECAP  = 4'd7;
	localparam logic [3:0] S_HDR   = 4'd8;
	localparam logic [3:0] S_PRD   = 4'd9;
	localparam logic [3:0] S_PAP   = 4'd10;
	localparam logic [3:0] S_LEN   = 4'd11;
	localparam logic [3:0] S_XRD   = 4'd12;
	localparam logic [3:0] S_XAP   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_LOAD);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					ctl.in_take = 1'b1;
					if (sts.in_final) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				ctl.scan_init = 1'b1;
				state_d = (sts.ovf || sts.cnt_zero) ? S_EOVF : S_SRD;
			end
			S_SRD: begin
				if (sts.p_ge_min) begin
					state_d = S_TOT;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_p  = 1'b1;
					state_d   = S_SCMP;
				end
			end
			S_SCMP: begin
				// first string sets the reference byte, the rest compare to it
				if (!sts.i_first && sts.mismatch) begin
					state_d = S_TOT;
				end else begin
					ctl.ref_ld = sts.i_first;
					if (sts.i_last) begin
						ctl.p_inc = 1'b1;
						ctl.i_clr = 1'b1;
					end else begin
						ctl.i_inc = 1'b1;
					end
					state_d = S_SRD;
				end
			end
			S_TOT: begin
				ctl.tot_ld = 1'b1;
				ctl.i_clr  = 1'b1;
				state_d    = S_CAP;
			end
			S_CAP: begin
				state_d = sts.cap_over ? S_ECAP : S_HDR;
			end
			S_EOVF: begin
				if (sts.slot_free) begin
					ctl.err        = 1'b1;
					ctl.err_status = ucpe_pkg::ST_OVF;
					ctl.set_clr    = 1'b1;
					state_d        = S_LOAD;
				end
			end
			S_ECAP: begin
				if (sts.slot_free) begin
					ctl.err        = 1'b1;
					ctl.err_status = ucpe_pkg::ST_NOSPACE;
					ctl.set_clr    = 1'b1;
					state_d        = S_LOAD;
				end
			end
			S_HDR: begin
				if (sts.slot_free) begin
					ctl.app     = 1'b1;
					ctl.app_src = ucpe_pkg::SRC_PLEN;
					ctl.j_zero  = 1'b1;
					state_d     = sts.p_zero ? S_LEN : S_PRD;
				end
			end
			S_PRD: begin
				ctl.rd_en = 1'b1;
				state_d   = S_PAP;
			end
			S_PAP: begin
				if (sts.slot_free) begin
					ctl.app     = 1'b1;
					ctl.app_src = ucpe_pkg::SRC_MEM;
					ctl.j_inc   = 1'b1;
					state_d     = sts.j_last_pfx ? S_LEN : S_PRD;
				end
			end
			S_LEN: begin
				if (sts.slot_free) begin
					ctl.app     = 1'b1;
					ctl.app_src = ucpe_pkg::SRC_SLEN;
					ctl.j_ld_p  = 1'b1;
					if (sts.len_gt_p) begin
						state_d = S_XRD;
					end else if (sts.i_last) begin
						ctl.app_last = 1'b1;
						ctl.set_clr  = 1'b1;
						state_d      = S_LOAD;
					end else begin
						ctl.i_inc = 1'b1;
					end
				end
			end
			S_XRD: begin
				ctl.rd_en = 1'b1;
				state_d   = S_XAP;
			end
			S_XAP: begin
				if (sts.slot_free) begin
					ctl.app     = 1'b1;
					ctl.app_src = ucpe_pkg::SRC_MEM;
					ctl.j_inc   = 1'b1;
					if (!sts.j_last_sfx) begin
						state_d = S_XRD;
					end else if (sts.i_last) begin
						ctl.app_last = 1'b1;
						ctl.set_clr  = 1'b1;
						state_d      = S_LOAD;
					end else begin
						ctl.i_inc = 1'b1;
						state_d   = S_LEN;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

// ===== sv/url_common_prefix_encoder.sv =====
// Top level: front-coding encoder for a set of strings sharing a common prefix.
// Load: one byte per cycle, input ready only between sets.
// After the final terminator: a check, a prefix scan of each prefix byte over the n strings,
// size check, then emission of length bytes and stored bytes (read via the store read port).
// Output words leave through one output register; a stalled consumer stalls emission.
// Reset clears set state and output valid and loads capacity 1023; the store is not cleared.
module url_common_prefix_encoder #(
	parameter int MAX_URLS    = 2,
	parameter int URL_MAX_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ucpe_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ucpe_pkg::out_t             out_data,
	input  logic                       cfg_wr_en,
	input  logic [ucpe_pkg::CAP_W-1:0] cfg_wr_data
);

	ucpe_pkg::ctl_t ctl;
	ucpe_pkg::sts_t sts;

	ucpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	ucpe_dp #(
		.MAX_URLS    (MAX_URLS),
		.URL_MAX_LEN (URL_MAX_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	// Error transactions carry no bytes and end the encoding
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ucpe_pkg::ST_OK
		|-> out_data.byte_count == 4'd0 && out_data.last_word)
		else $error("error result with bytes or without last_word");

	// Only the final word of an encoding may be partial
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ucpe_pkg::ST_OK && !out_data.last_word
		|-> out_data.byte_count == 4'd8)
		else $error("non-final word not full");

	// Good words carry one to eight bytes
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ucpe_pkg::ST_OK
		|-> out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8)
		else $error("bad byte count");

	// No input taken while the packer or scan is running
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.url_byte == 8'd0 && in_data.last_url
		|=> !in_ready)
		else $error("input ready right after final terminator");

endmodule
